// ===== rtl/core/bpfc_pkg.sv =====
// bpfc_pkg: shared types and constants for the bgra8 pixel format converter
// no dependencies; used by the csr interface and imported by every module of the block
package bpfc_pkg;

   localparam int FMT_W = 2;

   // output format codes, as written to the format register
   typedef enum logic [FMT_W-1:0] {
      FMT_BGRA8   = 2'd0,
      FMT_RGBA8   = 2'd1,
      FMT_RGB10A2 = 2'd2,
      FMT_RGBA16F = 2'd3
   } fmt_type;

   localparam logic [7:0]  ALPHA_8BIT  = 8'hFF;
   localparam logic [1:0]  ALPHA_2BIT  = 2'b11;
   localparam logic [15:0] HALF_ONE    = 16'h3C00;
   // half exponent field for a channel whose top set bit is bit 0 (e = -6, bias 15)
   localparam logic [4:0]  HALF_EXP_LO = 5'd9;

   // one channel after leading-one classification
   typedef struct packed {
      logic       zero;
      logic [2:0] pos;
      logic [7:0] mant;
      logic [7:0] raw;
   } chan_norm_type;

   // one classified request as it waits between front and back
   typedef struct packed {
      chan_norm_type blue;
      chan_norm_type green;
      chan_norm_type red;
      logic          last_pixel;
      fmt_type       fmt;
   } work_type;

endpackage

// ===== rtl/core/bpfc_ifs.sv =====
// bpfc_ifs: valid/ready channel interfaces for request, response and csr write
// depends on bpfc_pkg for the format width
interface bpfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   logic       last_pixel;
   modport source (output valid, blue, green, red, last_pixel, input ready);
   modport sink (input valid, blue, green, red, last_pixel, output ready);
endinterface

interface bpfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] pixel_word;
   logic        eight_bytes;
   logic        last_out;
   modport source (output valid, pixel_word, eight_bytes, last_out, input ready);
   modport sink (input valid, pixel_word, eight_bytes, last_out, output ready);
endinterface

interface bpfc_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bpfc_pkg::FMT_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/bpfc_front.sv =====
// bpfc_front: accepts requests, finds each channel's leading one and tags the format
// depends on bpfc_pkg and bpfc_req_if
module bpfc_front (
   input  logic              clock,
   input  logic              reset,
   bpfc_req_if.sink          req_ch,
   input  bpfc_pkg::fmt_type fmt,
   output bpfc_pkg::work_type q_data,
   output logic              q_valid,
   input  logic              q_ready
);
   import bpfc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   work_type data_ff;
   work_type data_in;
   logic     take;

   // leading-one position and left-aligned mantissa of one channel
   function automatic chan_norm_type normalize(input logic [7:0] c);
      chan_norm_type n;
      n.zero = (c == 8'd0);
      n.pos  = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (c[i]) n.pos = 3'(i);
      end
      n.mant = c << (3'd7 - n.pos);
      n.raw  = c;
      return n;
   endfunction

   // stage register opens when empty or when the queue takes its item
   assign req_ch.ready = !valid_ff || q_ready;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      data_in            = data_ff;
      valid_in           = valid_ff;
      if (take) begin
         data_in.blue       = normalize(req_ch.blue);
         data_in.green      = normalize(req_ch.green);
         data_in.red        = normalize(req_ch.red);
         data_in.last_pixel = req_ch.last_pixel;
         data_in.fmt        = fmt;
         valid_in           = 1'b1;
      end else if (q_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q_data  = data_ff;
   assign q_valid = valid_ff;

`ifndef SYNTHESIS
   // a nonzero red channel is left-aligned
   a_mant_aligned: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.red.zero |-> data_ff.red.mant[7])
      else $error("front: red mantissa not aligned");
   // blue zero flag agrees with the raw byte
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.blue.zero == (data_ff.blue.raw == 8'd0)))
      else $error("front: blue zero flag wrong");
   // an accepted request shows up in the stage next cycle
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> valid_ff && (data_ff.last_pixel == $past(req_ch.last_pixel)))
      else $error("front: accepted request not loaded");
`endif

endmodule

// ===== rtl/core/bpfc_queue.sv =====
// bpfc_queue: short fifo of classified requests between front and back
// depends on bpfc_pkg for the entry type
module bpfc_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  bpfc_pkg::work_type push_data,
   input  logic               push_valid,
   output logic               push_ready,
   output bpfc_pkg::work_type pop_data,
   output logic               pop_valid,
   input  logic               pop_ready
);
   import bpfc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   // a request held off by a full queue stays offered and unchanged
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |=> push_valid && $stable(push_data))
      else $error("queue: held request dropped or changed");
   // count moves by one on a lone push
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue: count did not rise");
   // pointers agree with the count when empty
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue: pointers differ while empty");
`endif

endmodule

// ===== rtl/core/bpfc_back.sv =====
// bpfc_back: converts a classified request to the packed word, with output register
// depends on bpfc_pkg and bpfc_rsp_if
module bpfc_back (
   input  logic               clock,
   input  logic               reset,
   input  bpfc_pkg::work_type work,
   input  logic               work_valid,
   output logic               work_ready,
   bpfc_rsp_if.source         rsp_ch
);
   import bpfc_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic [63:0] word_ff;
   logic [63:0] word_in;
   logic        eight_ff;
   logic        eight_in;
   logic        last_ff;
   logic        last_in;
   logic        load;

   // 8 bit channel to 10 bits by replicating the top bits
   function automatic logic [9:0] widen10(input logic [7:0] c);
      return {c, c[7:6]};
   endfunction

   // half of 4c/255 from the aligned mantissa m: s = 8m + floor(8m/255)
   function automatic logic [15:0] to_half(input chan_norm_type n);
      logic [10:0] y;
      logic [11:0] t;
      logic [11:0] s;
      logic [4:0]  ex;
      logic [9:0]  frac;
      y = {n.mant, 3'b000};
      t = {1'b0, y} + 12'(y[10:8]) + 12'd1;
      s = {1'b0, y} + 12'(t[11:8]);
      if (s[11]) begin
         // only a full-scale channel lands on exactly 4.0
         ex   = 5'(n.pos) + HALF_EXP_LO + 5'd1;
         frac = '0;
      end else begin
         ex   = 5'(n.pos) + HALF_EXP_LO;
         frac = s[9:0];
      end
      if (n.zero) begin
         return 16'h0000;
      end
      return {1'b0, ex, frac};
   endfunction

   assign work_ready = !valid_ff || rsp_ch.ready;
   assign load       = work_valid && work_ready;

   // pack the destination word per format
   always_comb begin
      word_in  = word_ff;
      eight_in = eight_ff;
      last_in  = last_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = work.last_pixel;
         eight_in = 1'b0;
         case (work.fmt)
            FMT_BGRA8: begin
               word_in = {32'd0, ALPHA_8BIT, work.red.raw, work.green.raw, work.blue.raw};
            end
            FMT_RGBA8: begin
               word_in = {32'd0, ALPHA_8BIT, work.blue.raw, work.green.raw, work.red.raw};
            end
            FMT_RGB10A2: begin
               word_in = {32'd0, ALPHA_2BIT, widen10(work.blue.raw),
                          widen10(work.green.raw), widen10(work.red.raw)};
            end
            FMT_RGBA16F: begin
               word_in  = {HALF_ONE, to_half(work.blue), to_half(work.green),
                           to_half(work.red)};
               eight_in = 1'b1;
            end
            default: begin
               word_in = '0;
            end
         endcase
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      eight_ff <= eight_in;
      last_ff  <= last_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.pixel_word  = word_ff;
   assign rsp_ch.eight_bytes = eight_ff;
   assign rsp_ch.last_out    = last_ff;

`ifndef SYNTHESIS
   // 4-byte words keep the upper half clear
   a_upper_clear: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !eight_ff |-> word_ff[63:32] == 32'd0)
      else $error("back: upper half set for 4-byte format");
   // half-float words carry alpha 1.0
   a_half_alpha: assert property (@(posedge clock) disable iff (reset)
      valid_ff && eight_ff |-> word_ff[63:48] == HALF_ONE)
      else $error("back: half-float alpha wrong");
   // a loaded item is presented next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff && last_ff == $past(work.last_pixel))
      else $error("back: loaded item not presented");
`endif

endmodule

// ===== rtl/core/bgra8_pixel_format_converter.sv =====
// bgra8_pixel_format_converter: top level, holds the format register and the stages
// depends on bpfc_pkg, bpfc_ifs, bpfc_front, bpfc_queue, bpfc_back
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    blue, green, red, last_pixel
//   rsp_ch    out   valid / ready    pixel_word, eight_bytes, last_out
//   csr_ch    in    valid / ready    data = output format (always ready)
//
// one request per clock sustained while rsp_ch.ready stays high; each request passes
// the front stage, a queue entry and the output register, in that order.
// reset is synchronous and active high; it empties all stages and sets the
// format to BGRA8.
// a stalled response holds the output register; the queue absorbs requests
// in flight until it fills, then req_ch.ready drops.
module bgra8_pixel_format_converter #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   bpfc_req_if.sink   req_ch,
   bpfc_rsp_if.source rsp_ch,
   bpfc_csr_if.sink   csr_ch
);
   import bpfc_pkg::*;

   fmt_type  fmt_ff;
   fmt_type  fmt_in;
   work_type front_data;
   work_type back_data;
   logic     front_valid;
   logic     front_ready;
   logic     back_valid;
   logic     back_ready;

   // format register
   assign csr_ch.ready = 1'b1;
   assign fmt_in       = (csr_ch.valid) ? fmt_type'(csr_ch.data) : fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_BGRA8;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   // front: accept and classify
   bpfc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .fmt     (fmt_ff),
      .q_data  (front_data),
      .q_valid (front_valid),
      .q_ready (front_ready)
   );

   // queue between front and back
   bpfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (front_data),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_data   (back_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready)
   );

   // back: convert and present
   bpfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work       (back_data),
      .work_valid (back_valid),
      .work_ready (back_ready),
      .rsp_ch     (rsp_ch)
   );

`ifndef SYNTHESIS
   // a csr write lands in the format register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_ch.valid |=> fmt_ff == $past(csr_ch.data))
      else $error("top: format write lost");
   // the format register only moves on a write
   a_fmt_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_ch.valid |=> $stable(fmt_ff))
      else $error("top: format changed without write");
   // nothing can reach the output right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("top: response valid after reset");
`endif

endmodule

// ===== verif/bgra8_pixel_format_converter_tb.sv =====
// bgra8_pixel_format_converter_tb: self-checking bench for the pixel format converter
// drives pixel requests and format writes, predicts every packed pixel and checks responses
// depends on bpfc_pkg, bpfc_ifs and the converter rtl
module bgra8_pixel_format_converter_tb;
   import bpfc_pkg::*;

   localparam int LATENCY       = 3;
   localparam int PHASE_ITEMS   = 66;
   localparam int RANDOM_PHASES = 8;
   localparam int PRESSURE_PHASE = 3;
   localparam int HOLD_CYCLES   = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       last_pixel;
   } pixel_req_type;

   typedef struct packed {
      logic [63:0] pixel_word;
      logic        eight_bytes;
      logic        last_out;
   } pixel_rsp_type;

   // expected packed pixels, one per accepted request
   class pixel_scoreboard_type;
      fmt_type       out_fmt = FMT_BGRA8;
      pixel_rsp_type expected_pixels[$];
      int unsigned   error_count = 0;

      // half-float of 4c/255, truncated: pick the highest exponent that keeps
      // the significand normalized
      function logic [15:0] to_half(logic [7:0] c);
         logic [31:0] scaled;
         if (c == 8'd0)
            return 16'h0000;
         for (int expo = 17; expo >= 9; expo--) begin
            scaled = ((32'(c) << 2) << (25 - expo)) / 32'd255;
            if (scaled >= 32'd1024)
               return {1'b0, 5'(expo), 10'(scaled - 32'd1024)};
         end
         return 16'h0000;
      endfunction

      function logic [9:0] widen_to_10(logic [7:0] c);
         return {c, c[7:6]};
      endfunction

      function pixel_rsp_type convert_pixel(pixel_req_type p);
         pixel_rsp_type res;
         res.eight_bytes = 1'b0;
         res.last_out    = p.last_pixel;
         case (out_fmt)
            FMT_BGRA8:   res.pixel_word = {32'd0, ALPHA_8BIT, p.red, p.green, p.blue};
            FMT_RGBA8:   res.pixel_word = {32'd0, ALPHA_8BIT, p.blue, p.green, p.red};
            FMT_RGB10A2: res.pixel_word = {32'd0, ALPHA_2BIT, widen_to_10(p.blue),
                                           widen_to_10(p.green), widen_to_10(p.red)};
            default: begin
               res.pixel_word  = {HALF_ONE, to_half(p.blue), to_half(p.green),
                                  to_half(p.red)};
               res.eight_bytes = 1'b1;
            end
         endcase
         return res;
      endfunction

      function void note_request(pixel_req_type p);
         expected_pixels.push_back(convert_pixel(p));
      endfunction

      function void report(string what, logic [63:0] want, logic [63:0] got);
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
      endfunction

      function void check_response(pixel_rsp_type got);
         pixel_rsp_type want;
         if (expected_pixels.size() == 0) begin
            report("unexpected response", 64'd0, got.pixel_word);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_word !== want.pixel_word)
            report("pixel_word", want.pixel_word, got.pixel_word);
         if (got.eight_bytes !== want.eight_bytes)
            report("eight_bytes", 64'(want.eight_bytes), 64'(got.eight_bytes));
         if (got.last_out !== want.last_out)
            report("last_out", 64'(want.last_out), 64'(got.last_out));
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned cycle_count = 0;
   bit src_gaps_on  = 1'b0;
   bit sink_gaps_on = 1'b0;
   bit hold_rsp_request = 1'b0;
   pixel_scoreboard_type sb = new();

   bpfc_req_if req_ch();
   bpfc_rsp_if rsp_ch();
   bpfc_csr_if csr_ch();

   bgra8_pixel_format_converter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // corner pixels, replayed under every format
   pixel_req_type directed_set[6] = '{
      '{8'h00, 8'h00, 8'h00, 1'b0},
      '{8'hFF, 8'hFF, 8'hFF, 1'b1},
      '{8'h01, 8'h80, 8'hFE, 1'b0},
      '{8'h40, 8'h7F, 8'h3F, 1'b1},
      '{8'h02, 8'h03, 8'h04, 1'b0},
      '{8'hAA, 8'h55, 8'hC0, 1'b1}
   };
   fmt_type directed_fmts[4] = '{FMT_BGRA8, FMT_RGBA16F, FMT_RGB10A2, FMT_RGBA8};
   fmt_type phase_fmts[RANDOM_PHASES] = '{FMT_RGBA16F, FMT_RGB10A2, FMT_BGRA8, FMT_RGBA16F,
                                          FMT_RGBA8, FMT_RGB10A2, FMT_BGRA8, FMT_RGBA16F};

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_response(pixel_rsp_type'{rsp_ch.pixel_word, rsp_ch.eight_bytes,
                                           rsp_ch.last_out});
   end

   // response ready: random stalls, plus one long hold on request
   initial begin
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (sink_gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'($urandom_range(1, 4));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic pixel_req_type random_pixel();
      pixel_req_type p;
      p.blue       = random_channel();
      p.green      = random_channel();
      p.red        = random_channel();
      p.last_pixel = ($urandom_range(0, 7) == 0);
      return p;
   endfunction

   // one request, with an optional idle burst ahead of it
   task automatic send_pixel(pixel_req_type p);
      if (src_gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.blue       <= p.blue;
      req_ch.green      <= p.green;
      req_ch.red        <= p.red;
      req_ch.last_pixel <= p.last_pixel;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(p);
   endtask

   // drain the block, then load a new output format
   task automatic change_format(fmt_type f);
      req_ch.valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= f;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      sb.out_fmt = f;
   endtask

   // stimulus
   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.blue       <= 8'd0;
      req_ch.green      <= 8'd0;
      req_ch.red        <= 8'd0;
      req_ch.last_pixel <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.data       <= FMT_BGRA8;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed corners under each format
      src_gaps_on  = 1'b1;
      sink_gaps_on = 1'b1;
      foreach (directed_fmts[f]) begin
         change_format(directed_fmts[f]);
         foreach (directed_set[i])
            send_pixel(directed_set[i]);
      end

      // random phases; one long response hold, and a quiet final phase
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         src_gaps_on  = (ph != PRESSURE_PHASE) && (ph != RANDOM_PHASES - 1);
         sink_gaps_on = (ph != RANDOM_PHASES - 1);
         change_format(phase_fmts[ph]);
         if (ph == PRESSURE_PHASE)
            hold_rsp_request = 1'b1;
         repeat (PHASE_ITEMS)
            send_pixel(random_pixel());
      end
      req_ch.valid <= 1'b0;

      // drain and finish
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_pixels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
